/* design/nst_pkg.sv */
// ----------------------------------------------------------------------------
// nst_pkg
// Shared types, token codes and byte classification for the note script
// tokenizer.
// ----------------------------------------------------------------------------
package nst_pkg;

    // token kinds on the result side
    localparam logic [3:0] KIND_LSQUARE = 4'd0;
    localparam logic [3:0] KIND_RSQUARE = 4'd1;
    localparam logic [3:0] KIND_LCURLY  = 4'd2;
    localparam logic [3:0] KIND_RCURLY  = 4'd3;
    localparam logic [3:0] KIND_EQUALS  = 4'd4;
    localparam logic [3:0] KIND_NOTES   = 4'd5;
    localparam logic [3:0] KIND_PCM     = 4'd6;
    localparam logic [3:0] KIND_NOTE    = 4'd7;
    localparam logic [3:0] KIND_NUMBER  = 4'd8;
    localparam logic [3:0] KIND_STRING  = 4'd9;

    // byte codes
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_SHARP  = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_H = 8'h48;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_H = 8'h68;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;

    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    // covers word lengths up to 63
    localparam int CNT_W = 6;

    // one token job handed from the front to the back
    typedef struct packed {
        logic [3:0]       kind;
        logic             has_text;
        logic [CNT_W-1:0] count;
        logic             trunc;
        logic [15:0]      line;
        logic             bank;
    } cmd_t;

    // word buffer release from the back
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_note_name(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_H)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_H)) || (c == CH_DASH);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE) || (c == CH_COMMA);
    endfunction

    // byte at position i of the keyword NOTES
    function automatic logic notes_char_ok(input logic [2:0] i, input logic [7:0] c);
        logic ok;
        unique case (i)
            3'd0:    ok = (c == 8'h4E);
            3'd1:    ok = (c == 8'h4F);
            3'd2:    ok = (c == 8'h54);
            3'd3:    ok = (c == 8'h45);
            3'd4:    ok = (c == 8'h53);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // byte at position i of the keyword PCM
    function automatic logic pcm_char_ok(input logic [1:0] i, input logic [7:0] c);
        logic ok;
        unique case (i)
            2'd0:    ok = (c == 8'h50);
            2'd1:    ok = (c == 8'h43);
            2'd2:    ok = (c == 8'h4D);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

/* design/nst_ram.sv */
// ----------------------------------------------------------------------------
// nst_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/nst_front.sv */
// ----------------------------------------------------------------------------
// nst_front
// Takes one byte per transaction, tracks comments, lines and the word under
// way, classifies finished words and queues token jobs for the back.
// ----------------------------------------------------------------------------
module nst_front #(
    parameter int MAX_WORD = 32,
    localparam int IW = $clog2(MAX_WORD)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          char_code,
    input  logic                end_of_stream,
    input  logic                fifo_room,
    input  nst_pkg::rel_t       rel,
    output logic                cmd0_valid,
    output nst_pkg::cmd_t       cmd0,
    output logic                cmd1_valid,
    output nst_pkg::cmd_t       cmd1,
    output logic                wr_en,
    output logic [IW:0]         wr_addr,
    output logic [7:0]          wr_data
);

    localparam int LW = $clog2(MAX_WORD + 1);

    typedef enum logic [5:0] {
        PH_START  = 6'b000001,
        PH_DIGITS = 6'b000010,
        PH_LETTER = 6'b000100,
        PH_SHARP  = 6'b001000,
        PH_OK     = 6'b010000,
        PH_FAIL   = 6'b100000
    } phase_t;

    logic [LW-1:0] len_reg, len_next, len_w;
    logic          ovf_reg, ovf_next, ovf_w;
    phase_t        phase_reg, phase_next, phase_w;
    logic          nz_reg, nz_next, nz_w;
    logic          num_reg, num_next, num_w;
    logic          mn_reg, mn_next, mn_w;
    logic          mp_reg, mp_next, mp_w;
    logic          com_reg, com_next;
    logic [15:0]   line_reg, line_next, line_mid, line_inc;
    logic          wbank_reg, wbank_next;
    logic [1:0]    busy_reg, busy_next;

    logic          accept;
    logic          semi, delim, spec, app, spec_hit, flush;
    logic [3:0]    spec_kind;
    logic          word_valid, is_notes, is_pcm, word_text;
    logic [3:0]    word_kind;
    nst_pkg::cmd_t word_cmd, spec_cmd;

    assign full   = busy_reg[wbank_reg] || !fifo_room;
    assign accept = push && !full;

    always_comb
    begin
        spec_hit  = 1'b1;
        spec_kind = nst_pkg::KIND_LSQUARE;
        unique case (char_code)
            nst_pkg::CH_LSQ:    spec_kind = nst_pkg::KIND_LSQUARE;
            nst_pkg::CH_RSQ:    spec_kind = nst_pkg::KIND_RSQUARE;
            nst_pkg::CH_LCURLY: spec_kind = nst_pkg::KIND_LCURLY;
            nst_pkg::CH_RCURLY: spec_kind = nst_pkg::KIND_RCURLY;
            nst_pkg::CH_EQUALS: spec_kind = nst_pkg::KIND_EQUALS;
            default:            spec_hit  = 1'b0;
        endcase
    end

    assign semi  = !com_reg && (char_code == nst_pkg::CH_SEMI);
    assign delim = !com_reg && !semi && nst_pkg::is_blank(char_code);
    assign spec  = !com_reg && !semi && !delim && spec_hit;
    assign app   = !com_reg && !semi && !delim && !spec_hit;
    assign flush = delim || spec || end_of_stream;

    assign line_inc = (line_reg == nst_pkg::LINE_MAX) ? line_reg : line_reg + 16'd1;
    assign line_mid = semi ? line_inc : line_reg;

    // word state with this byte appended
    always_comb
    begin
        len_w   = len_reg;
        ovf_w   = ovf_reg;
        phase_w = phase_reg;
        nz_w    = nz_reg;
        num_w   = num_reg;
        mn_w    = mn_reg;
        mp_w    = mp_reg;
        if (app)
        begin
            if (len_reg < LW'(MAX_WORD))
            begin
                len_w = len_reg + LW'(1);
            end
            else
            begin
                ovf_w = 1'b1;
            end
            if (!(nst_pkg::is_digit(char_code) || char_code == nst_pkg::CH_DASH))
            begin
                num_w = 1'b0;
            end
            if (len_reg < LW'(5))
            begin
                mn_w = mn_reg && nst_pkg::notes_char_ok(len_reg[2:0], char_code);
            end
            if (len_reg < LW'(3))
            begin
                mp_w = mp_reg && nst_pkg::pcm_char_ok(len_reg[1:0], char_code);
            end
            unique case (phase_reg)
                PH_START, PH_DIGITS:
                begin
                    if (nst_pkg::is_digit(char_code))
                    begin
                        if (char_code != nst_pkg::CH_ZERO)
                        begin
                            nz_w = 1'b1;
                        end
                        phase_w = PH_DIGITS;
                    end
                    else if (phase_reg == PH_DIGITS && nst_pkg::is_note_name(char_code))
                    begin
                        phase_w = (char_code == nst_pkg::CH_DASH) ? PH_OK : PH_LETTER;
                    end
                    else
                    begin
                        phase_w = PH_FAIL;
                    end
                end
                PH_LETTER:
                begin
                    phase_w = (char_code == nst_pkg::CH_SHARP ||
                               char_code == nst_pkg::CH_LOWER_B) ? PH_SHARP : PH_OK;
                end
                PH_SHARP: phase_w = PH_OK;
                PH_OK, PH_FAIL: phase_w = phase_reg;
                default: phase_w = PH_FAIL;
            endcase
        end
    end

    // classify the finished word
    always_comb
    begin
        is_notes   = mn_w && (len_w == LW'(5)) && !ovf_w;
        is_pcm     = mp_w && (len_w == LW'(3)) && !ovf_w;
        word_text  = !(is_notes || is_pcm);
        word_valid = flush && ((len_w != '0) || ovf_w);
        priority if (is_notes)
            word_kind = nst_pkg::KIND_NOTES;
        else if (is_pcm)
            word_kind = nst_pkg::KIND_PCM;
        else if (phase_w == PH_OK && nz_w)
            word_kind = nst_pkg::KIND_NOTE;
        else if (num_w)
            word_kind = nst_pkg::KIND_NUMBER;
        else
            word_kind = nst_pkg::KIND_STRING;

        word_cmd.kind     = word_kind;
        word_cmd.has_text = word_text;
        word_cmd.count    = nst_pkg::CNT_W'(len_w);
        word_cmd.trunc    = ovf_w && word_text;
        word_cmd.line     = line_mid;
        word_cmd.bank     = wbank_reg;

        spec_cmd.kind     = spec_kind;
        spec_cmd.has_text = 1'b0;
        spec_cmd.count    = '0;
        spec_cmd.trunc    = 1'b0;
        spec_cmd.line     = line_reg;
        spec_cmd.bank     = 1'b0;
    end

    assign cmd0_valid = accept && (word_valid || spec);
    assign cmd0       = word_valid ? word_cmd : spec_cmd;
    assign cmd1_valid = accept && word_valid && spec;
    assign cmd1       = spec_cmd;

    assign wr_en   = accept && app && (len_reg < LW'(MAX_WORD));
    assign wr_addr = {wbank_reg, len_reg[IW-1:0]};
    assign wr_data = char_code;

    always_comb
    begin
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        phase_next = phase_reg;
        nz_next    = nz_reg;
        num_next   = num_reg;
        mn_next    = mn_reg;
        mp_next    = mp_reg;
        com_next   = com_reg;
        line_next  = line_reg;
        wbank_next = wbank_reg;
        busy_next  = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            if (flush)
            begin
                len_next   = '0;
                ovf_next   = 1'b0;
                phase_next = PH_START;
                nz_next    = 1'b0;
                num_next   = 1'b1;
                mn_next    = 1'b1;
                mp_next    = 1'b1;
            end
            else
            begin
                len_next   = len_w;
                ovf_next   = ovf_w;
                phase_next = phase_w;
                nz_next    = nz_w;
                num_next   = num_w;
                mn_next    = mn_w;
                mp_next    = mp_w;
            end
            if (semi || (delim && char_code == nst_pkg::CH_LF))
            begin
                line_next = line_inc;
            end
            if (end_of_stream)
                com_next = 1'b0;
            else if (com_reg)
                com_next = !(char_code == nst_pkg::CH_LF || char_code == nst_pkg::CH_CR);
            else
                com_next = semi;
            // text words keep their buffer until the back has read it out
            if (word_valid && word_text)
            begin
                wbank_next           = !wbank_reg;
                busy_next[wbank_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            phase_reg <= PH_START;
            nz_reg    <= 1'b0;
            num_reg   <= 1'b1;
            mn_reg    <= 1'b1;
            mp_reg    <= 1'b1;
            com_reg   <= 1'b0;
            line_reg  <= 16'd1;
            wbank_reg <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            phase_reg <= phase_next;
            nz_reg    <= nz_next;
            num_reg   <= num_next;
            mn_reg    <= mn_next;
            mp_reg    <= mp_next;
            com_reg   <= com_next;
            line_reg  <= line_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

/* design/nst_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// nst_cmd_fifo
// Four-entry queue of token jobs; takes up to two jobs per cycle.
// ----------------------------------------------------------------------------
module nst_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push0,
    input  nst_pkg::cmd_t data0,
    input  logic          push1,
    input  nst_pkg::cmd_t data1,
    output logic          room,
    input  logic          pop,
    output logic          head_valid,
    output nst_pkg::cmd_t head
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    nst_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next, wptr_plus;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [PW:0]   cnt_reg, cnt_next;

    assign wptr_plus  = wptr_reg + PW'(1);
    assign room       = cnt_reg <= (PW + 1)'(DEPTH - 2);
    assign head_valid = cnt_reg != '0;
    assign head       = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg + PW'(push0) + PW'(push1);
        rptr_next = rptr_reg + PW'(pop);
        cnt_next  = cnt_reg + (PW + 1)'(push0) + (PW + 1)'(push1) - (PW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem_reg[wptr_reg] <= data0;
        end
        if (push1)
        begin
            mem_reg[wptr_plus] <= data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* design/nst_back.sv */
// ----------------------------------------------------------------------------
// nst_back
// Carries out queued token jobs: reads word bytes from the buffer and
// presents one result per transaction through a read stage and an output
// register.
// ----------------------------------------------------------------------------
module nst_back #(
    parameter int MAX_WORD = 32,
    localparam int IW = $clog2(MAX_WORD)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  nst_pkg::cmd_t head,
    output logic          head_pop,
    output nst_pkg::rel_t rel,
    output logic          rd_en,
    output logic [IW:0]   rd_addr,
    input  logic [7:0]    rd_data,
    output logic          empty,
    input  logic          pop,
    output logic [3:0]    kind,
    output logic [7:0]    text_byte,
    output logic          has_text,
    output logic          last,
    output logic [15:0]   line,
    output logic          truncated
);

    logic [IW-1:0] idx_reg, idx_next;
    logic          s1_valid_reg, s1_valid_next;
    logic [3:0]    s1_kind_reg;
    logic          s1_text_reg, s1_last_reg, s1_trunc_reg;
    logic [15:0]   s1_line_reg;
    logic          out_valid_reg, out_valid_next;
    logic [3:0]    kind_reg;
    logic [7:0]    byte_reg;
    logic          text_reg, last_reg, trunc_reg;
    logic [15:0]   line_reg;

    logic issue, elem_last, s1_adv, out_take;

    assign out_take  = pop && out_valid_reg;
    assign s1_adv    = !out_valid_reg || out_take;
    assign issue     = head_valid && (!s1_valid_reg || s1_adv);
    assign elem_last = !head.has_text ||
                       ((nst_pkg::CNT_W'(idx_reg) + nst_pkg::CNT_W'(1)) == head.count);

    assign head_pop  = issue && elem_last;
    assign rel.valid = issue && elem_last && head.has_text;
    assign rel.bank  = head.bank;
    assign rd_en     = issue && head.has_text;
    assign rd_addr   = {head.bank, idx_reg};

    always_comb
    begin
        idx_next = idx_reg;
        if (issue)
        begin
            idx_next = elem_last ? '0 : idx_reg + IW'(1);
        end
        s1_valid_next = issue ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        if (s1_valid_reg && s1_adv)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // read stage metadata; the buffer data lands alongside it
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_kind_reg  <= head.kind;
            s1_text_reg  <= head.has_text;
            s1_last_reg  <= elem_last;
            s1_trunc_reg <= head.trunc;
            s1_line_reg  <= head.line;
        end
        if (s1_valid_reg && s1_adv)
        begin
            kind_reg  <= s1_kind_reg;
            byte_reg  <= s1_text_reg ? rd_data : 8'd0;
            text_reg  <= s1_text_reg;
            last_reg  <= s1_last_reg;
            trunc_reg <= s1_trunc_reg;
            line_reg  <= s1_line_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty     = !out_valid_reg;
    assign kind      = kind_reg;
    assign text_byte = byte_reg;
    assign has_text  = text_reg;
    assign last      = last_reg;
    assign line      = line_reg;
    assign truncated = trunc_reg;

endmodule

/* design/note_script_tokenizer.sv */
// path: a token's first result passes the job queue, read stage and output register
// after the byte ending it is taken; a word's n bytes give one popped result per cycle
// throughput: one byte per cycle while the job queue has room for two jobs and a
// word buffer is free; the back drains one popped result per cycle via its buffer read
// reset: clears comment, word and queue state, line count starts at 1; the word
// buffers are not cleared
// ----------------------------------------------------------------------------
// note_script_tokenizer
// Cuts a stream of script bytes into tokens of a note script, with a front
// that classifies and a back that emits token bytes from two word buffers.
// ----------------------------------------------------------------------------
module note_script_tokenizer #(
    parameter int MAX_WORD = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_code,
    input  logic        end_of_stream,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  kind,
    output logic [7:0]  text_byte,
    output logic        has_text,
    output logic        last,
    output logic [15:0] line,
    output logic        truncated
);

    localparam int IW = $clog2(MAX_WORD);

    logic          fifo_room;
    nst_pkg::rel_t rel;
    logic          cmd0_valid, cmd1_valid;
    nst_pkg::cmd_t cmd0, cmd1, head;
    logic          head_valid, head_pop;
    logic          wr_en, rd_en;
    logic [IW:0]   wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    nst_front #(
        .MAX_WORD (MAX_WORD)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_code     (char_code),
        .end_of_stream (end_of_stream),
        .fifo_room     (fifo_room),
        .rel           (rel),
        .cmd0_valid    (cmd0_valid),
        .cmd0          (cmd0),
        .cmd1_valid    (cmd1_valid),
        .cmd1          (cmd1),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    nst_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (cmd0_valid),
        .data0      (cmd0),
        .push1      (cmd1_valid),
        .data1      (cmd1),
        .room       (fifo_room),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    nst_ram #(
        .WIDTH (8),
        .DEPTH (2 * (2 ** IW))
    ) u_word_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    nst_back #(
        .MAX_WORD (MAX_WORD)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .rel        (rel),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .text_byte  (text_byte),
        .has_text   (has_text),
        .last       (last),
        .line       (line),
        .truncated  (truncated)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the note script tokenizer. A short table of script
// bytes comes first, then random script fragments under three push and pop
// idling patterns. Every result is checked against a token predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int WORD_MAX    = 32;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  text_byte;
        logic        has_text;
        logic        last;
        logic [15:0] line;
        logic        truncated;
    } tok_t;

    typedef enum logic [5:0] {
        NP_START      = 6'b000001,
        NP_DIGITS     = 6'b000010,
        NP_NAME       = 6'b000100,
        NP_ACCIDENTAL = 6'b001000,
        NP_GOOD       = 6'b010000,
        NP_BAD        = 6'b100000
    } note_phase_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eos;
        logic        pin;
        logic [3:0]  kind;
        logic [15:0] line;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  char_code = 8'd0;
    logic        end_of_stream = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  kind;
    logic [7:0]  text_byte;
    logic        has_text;
    logic        last;
    logic [15:0] line;
    logic        truncated;

    // predictor state
    logic [7:0]  word_buf [WORD_MAX];
    int          word_len = 0;
    logic        word_cut = 1'b0;
    logic        word_nonzero = 1'b0;
    logic        word_numeric = 1'b1;
    note_phase_t note_ph = NP_START;
    logic        in_cmt = 1'b0;
    logic [15:0] line_cnt = 16'd1;

    tok_t        exp_tokens [$];
    tok_t        step_tok;
    tok_t        want_tok;
    int          step_count;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          byte_cnt = 0;
    int          checked_cnt = 0;
    int          err_cnt = 0;
    int          cycle_cnt = 0;

    note_script_tokenizer #(
        .MAX_WORD (WORD_MAX)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_code     (char_code),
        .end_of_stream (end_of_stream),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .text_byte     (text_byte),
        .has_text      (has_text),
        .last          (last),
        .line          (line),
        .truncated     (truncated)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic dir_row_t row(input logic [7:0] ch, input logic eos,
                                     input logic pin, input logic [3:0] k,
                                     input logic [15:0] ln);
        return {ch, eos, pin, k, ln};
    endfunction

    // pinned rows give exactly one token with the kind and line shown
    dir_row_t dir_rows [25] = '{
        row(nst_pkg::CH_LSQ,    1'b0, 1'b1, nst_pkg::KIND_LSQUARE, 16'd1),
        row(nst_pkg::CH_RSQ,    1'b0, 1'b1, nst_pkg::KIND_RSQUARE, 16'd1),
        row(nst_pkg::CH_LCURLY, 1'b0, 1'b1, nst_pkg::KIND_LCURLY,  16'd1),
        row(nst_pkg::CH_RCURLY, 1'b0, 1'b1, nst_pkg::KIND_RCURLY,  16'd1),
        row("N",                1'b0, 1'b0, nst_pkg::KIND_NOTES,   16'd0),
        row("O",                1'b0, 1'b0, nst_pkg::KIND_NOTES,   16'd0),
        row("T",                1'b0, 1'b0, nst_pkg::KIND_NOTES,   16'd0),
        row("E",                1'b0, 1'b0, nst_pkg::KIND_NOTES,   16'd0),
        row("S",                1'b1, 1'b1, nst_pkg::KIND_NOTES,   16'd1),
        row("P",                1'b0, 1'b0, nst_pkg::KIND_PCM,     16'd0),
        row("C",                1'b0, 1'b0, nst_pkg::KIND_PCM,     16'd0),
        row("M",                1'b0, 1'b0, nst_pkg::KIND_PCM,     16'd0),
        row(nst_pkg::CH_COMMA,  1'b0, 1'b1, nst_pkg::KIND_PCM,     16'd1),
        row("4",                1'b0, 1'b0, nst_pkg::KIND_NOTE,    16'd0),
        row("c",                1'b0, 1'b0, nst_pkg::KIND_NOTE,    16'd0),
        row(nst_pkg::CH_SHARP,  1'b0, 1'b0, nst_pkg::KIND_NOTE,    16'd0),
        row("x",                1'b0, 1'b0, nst_pkg::KIND_NOTE,    16'd0),
        row(nst_pkg::CH_LF,     1'b0, 1'b0, nst_pkg::KIND_NOTE,    16'd0),
        row(nst_pkg::CH_SEMI,   1'b0, 1'b0, nst_pkg::KIND_STRING,  16'd0),
        row(nst_pkg::CH_CR,     1'b0, 1'b0, nst_pkg::KIND_STRING,  16'd0),
        row(nst_pkg::CH_ZERO,   1'b0, 1'b0, nst_pkg::KIND_STRING,  16'd0),
        row(nst_pkg::CH_DASH,   1'b0, 1'b0, nst_pkg::KIND_STRING,  16'd0),
        row(8'hFF,              1'b0, 1'b0, nst_pkg::KIND_STRING,  16'd0),
        row(8'h00,              1'b1, 1'b0, nst_pkg::KIND_STRING,  16'd0),
        row(nst_pkg::CH_EQUALS, 1'b0, 1'b1, nst_pkg::KIND_EQUALS,  16'd3)
    };

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        err_cnt++;
        $display("mismatch at result %0d: %s got %0h want %0h",
                 checked_cnt, what, got, want);
    endtask

    function automatic void emit_token(input logic [3:0] k, input logic [7:0] b,
                                       input logic txt, input logic lst,
                                       input logic cut);
        tok_t t;
        t = {k, b, txt, lst, line_cnt, cut};
        exp_tokens.push_back(t);
        step_tok = t;
        step_count++;
    endfunction

    function automatic void bump_line();
        if (line_cnt != nst_pkg::LINE_MAX)
            line_cnt++;
    endfunction

    function automatic void close_word();
        logic [3:0] k;
        if (word_len != 0 || word_cut)
        begin
            if (!word_cut && word_len == 5 &&
                {word_buf[0], word_buf[1], word_buf[2], word_buf[3], word_buf[4]} == "NOTES")
                emit_token(nst_pkg::KIND_NOTES, 8'd0, 1'b0, 1'b1, 1'b0);
            else if (!word_cut && word_len == 3 &&
                     {word_buf[0], word_buf[1], word_buf[2]} == "PCM")
                emit_token(nst_pkg::KIND_PCM, 8'd0, 1'b0, 1'b1, 1'b0);
            else
            begin
                if (note_ph == NP_GOOD && word_nonzero)
                    k = nst_pkg::KIND_NOTE;
                else if (word_numeric)
                    k = nst_pkg::KIND_NUMBER;
                else
                    k = nst_pkg::KIND_STRING;
                for (int i = 0; i < word_len; i++)
                    emit_token(k, word_buf[i], 1'b1, i == word_len - 1, word_cut);
            end
        end
        word_len     = 0;
        word_cut     = 1'b0;
        word_nonzero = 1'b0;
        word_numeric = 1'b1;
        note_ph      = NP_START;
    endfunction

    function automatic void add_word_byte(input logic [7:0] c);
        logic dig;
        logic name;
        dig  = (c >= nst_pkg::CH_ZERO) && (c <= nst_pkg::CH_NINE);
        name = ((c >= nst_pkg::CH_UPPER_A) && (c <= nst_pkg::CH_UPPER_H)) ||
               ((c >= nst_pkg::CH_LOWER_A) && (c <= nst_pkg::CH_LOWER_H)) ||
               (c == nst_pkg::CH_DASH);
        if (word_len < WORD_MAX)
        begin
            word_buf[word_len] = c;
            word_len++;
        end
        else
            word_cut = 1'b1;
        if (!(dig || c == nst_pkg::CH_DASH))
            word_numeric = 1'b0;
        case (note_ph)
            NP_START, NP_DIGITS:
            begin
                if (dig)
                begin
                    if (c != nst_pkg::CH_ZERO)
                        word_nonzero = 1'b1;
                    note_ph = NP_DIGITS;
                end
                else if (note_ph == NP_DIGITS && name)
                    note_ph = (c == nst_pkg::CH_DASH) ? NP_GOOD : NP_NAME;
                else
                    note_ph = NP_BAD;
            end
            NP_NAME:
                note_ph = (c == nst_pkg::CH_SHARP || c == nst_pkg::CH_LOWER_B) ?
                          NP_ACCIDENTAL : NP_GOOD;
            NP_ACCIDENTAL:
                note_ph = NP_GOOD;
            default:
                ;
        endcase
    endfunction

    function automatic void predict_tokens(input logic [7:0] c, input logic eos);
        step_count = 0;
        if (in_cmt)
        begin
            if (c == nst_pkg::CH_LF || c == nst_pkg::CH_CR)
                in_cmt = 1'b0;
        end
        else if (c == nst_pkg::CH_SEMI)
        begin
            in_cmt = 1'b1;
            bump_line();
        end
        else if ((c >= nst_pkg::CH_TAB && c <= nst_pkg::CH_CR) ||
                 c == nst_pkg::CH_SPACE || c == nst_pkg::CH_COMMA)
        begin
            close_word();
            // the line feed counts after the word it ends
            if (c == nst_pkg::CH_LF)
                bump_line();
        end
        else
        begin
            case (c)
                nst_pkg::CH_LSQ:
                begin
                    close_word();
                    emit_token(nst_pkg::KIND_LSQUARE, 8'd0, 1'b0, 1'b1, 1'b0);
                end
                nst_pkg::CH_RSQ:
                begin
                    close_word();
                    emit_token(nst_pkg::KIND_RSQUARE, 8'd0, 1'b0, 1'b1, 1'b0);
                end
                nst_pkg::CH_LCURLY:
                begin
                    close_word();
                    emit_token(nst_pkg::KIND_LCURLY, 8'd0, 1'b0, 1'b1, 1'b0);
                end
                nst_pkg::CH_RCURLY:
                begin
                    close_word();
                    emit_token(nst_pkg::KIND_RCURLY, 8'd0, 1'b0, 1'b1, 1'b0);
                end
                nst_pkg::CH_EQUALS:
                begin
                    close_word();
                    emit_token(nst_pkg::KIND_EQUALS, 8'd0, 1'b0, 1'b1, 1'b0);
                end
                default:
                    add_word_byte(c);
            endcase
        end
        if (eos)
        begin
            close_word();
            in_cmt = 1'b0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push          <= 1'b1;
        char_code     <= c;
        end_of_stream <= eos;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_tokens(c, eos);
        byte_cnt++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (exp_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(nst_pkg::CH_LOWER_A, 8'h7A));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(nst_pkg::CH_ZERO, nst_pkg::CH_NINE));
    endfunction

    function automatic logic [7:0] rand_ctrl_blank();
        return 8'($urandom_range(nst_pkg::CH_TAB, nst_pkg::CH_CR));
    endfunction

    // one piece of script: mostly words and tokens, some comments and noise
    task automatic send_fragment();
        int         sel;
        int         n;
        logic [7:0] c;
        sel = $urandom_range(99);
        if (sel < 18)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(rand_digit(), 1'b0);
            n = $urandom_range(16);
            if (n < 8)
                c = 8'(nst_pkg::CH_UPPER_A + n);
            else if (n < 16)
                c = 8'(nst_pkg::CH_LOWER_A + n - 8);
            else
                c = nst_pkg::CH_DASH;
            send_byte(c, 1'b0);
            if ($urandom_range(1))
                send_byte($urandom_range(1) ? nst_pkg::CH_SHARP : nst_pkg::CH_LOWER_B, 1'b0);
            repeat ($urandom_range(2))
                send_byte($urandom_range(1) ? rand_letter() : rand_digit(), 1'b0);
        end
        else if (sel < 30)
        begin
            repeat ($urandom_range(1, 6))
                send_byte($urandom_range(3) == 0 ? nst_pkg::CH_DASH : rand_digit(), 1'b0);
        end
        else if (sel < 44)
        begin
            repeat ($urandom_range(1, 8))
            begin
                n = $urandom_range(7);
                if (n == 0)
                    c = 8'($urandom_range(128, 255));
                else if (n == 1)
                    c = rand_digit();
                else
                    c = rand_letter();
                send_byte(c, 1'b0);
            end
        end
        else if (sel < 50)
        begin
            case ($urandom_range(4))
                0: send_text("NOTES");
                1: send_text("PCM");
                2: send_text("NOTE");
                3: send_text("PCMB");
                default: send_text("NOTESS");
            endcase
        end
        else if (sel < 53)
        begin
            // long word, cut at the store size if it runs over
            repeat ($urandom_range(30, 40)) send_byte(rand_letter(), 1'b0);
        end
        else if (sel < 65)
        begin
            case ($urandom_range(4))
                0: send_byte(nst_pkg::CH_LSQ, 1'b0);
                1: send_byte(nst_pkg::CH_RSQ, 1'b0);
                2: send_byte(nst_pkg::CH_LCURLY, 1'b0);
                3: send_byte(nst_pkg::CH_RCURLY, 1'b0);
                default: send_byte(nst_pkg::CH_EQUALS, 1'b0);
            endcase
        end
        else if (sel < 75)
        begin
            send_byte(nst_pkg::CH_SEMI, 1'b0);
            repeat ($urandom_range(4))
            begin
                c = 8'($urandom_range(255));
                if (c == nst_pkg::CH_LF || c == nst_pkg::CH_CR)
                    c = nst_pkg::CH_SEMI;
                send_byte(c, 1'b0);
            end
            n = $urandom_range(5);
            if (n == 0)
                send_byte(rand_letter(), 1'b1);
            else
                send_byte(n < 3 ? nst_pkg::CH_CR : nst_pkg::CH_LF, 1'b0);
        end
        else if (sel < 79)
            send_byte($urandom_range(1) ? rand_letter() : nst_pkg::CH_SPACE, 1'b1);
        else if (sel < 89)
            send_byte($urandom_range(1) ? rand_ctrl_blank() : nst_pkg::CH_SPACE, 1'b0);
        else
            send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);

        // a word left open may continue past the next comment
        if (sel < 53 && $urandom_range(3) != 0)
        begin
            case ($urandom_range(3))
                0: send_byte(nst_pkg::CH_COMMA, 1'b0);
                1: send_byte(nst_pkg::CH_LF, 1'b0);
                2: send_byte(rand_ctrl_blank(), 1'b0);
                default: send_byte(nst_pkg::CH_SPACE, 1'b0);
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // result side: check each transaction against the oldest predicted token
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (exp_tokens.size() == 0)
                report_mismatch("no token pending, kind", 16'(kind), 16'd0);
            else
            begin
                want_tok = exp_tokens.pop_front();
                if (kind !== want_tok.kind)
                    report_mismatch("kind", 16'(kind), 16'(want_tok.kind));
                if (text_byte !== want_tok.text_byte)
                    report_mismatch("text_byte", 16'(text_byte), 16'(want_tok.text_byte));
                if (has_text !== want_tok.has_text)
                    report_mismatch("has_text", 16'(has_text), 16'(want_tok.has_text));
                if (last !== want_tok.last)
                    report_mismatch("last", 16'(last), 16'(want_tok.last));
                if (line !== want_tok.line)
                    report_mismatch("line", line, want_tok.line);
                if (truncated !== want_tok.truncated)
                    report_mismatch("truncated", 16'(truncated), 16'(want_tok.truncated));
            end
            checked_cnt++;
        end
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].ch, dir_rows[i].eos);
            if (dir_rows[i].pin &&
                (step_count != 1 || step_tok.kind != dir_rows[i].kind ||
                 step_tok.line != dir_rows[i].line || step_tok.has_text ||
                 !step_tok.last || step_tok.truncated))
                report_mismatch("directed token kind", 16'(step_tok.kind),
                                16'(dir_rows[i].kind));
        end
        wait_drained();

        send_idle_pct  = 20;
        recv_stall_pct = 68;
        while (byte_cnt < 165)
            send_fragment();
        wait_drained();

        send_idle_pct  = 68;
        recv_stall_pct = 20;
        while (byte_cnt < 295)
            send_fragment();
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (byte_cnt < 415)
            send_fragment();

        push <= 1'b0;
        while (exp_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (exp_tokens.size() != 0)
            report_mismatch("tokens left over", 16'(exp_tokens.size()), 16'd0);

        $display("sent %0d script bytes: table rows, then words, keywords, long words,",
                 byte_cnt);
        $display("comments and bracket tokens under three idling patterns; %0d results, %0d bad",
                 checked_cnt, err_cnt);
        if (err_cnt == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

/* note_script_tokenizer.f */
design/nst_pkg.sv
design/nst_ram.sv
design/nst_front.sv
design/nst_cmd_fifo.sv
design/nst_back.sv
design/note_script_tokenizer.sv
dv/tb.sv
